// ===== hw/rtl/rgb_to_gray_bitplane_packer_macros.svh =====
// Assertion helpers used by the packer RTL
`ifndef RGB_TO_GRAY_BITPLANE_PACKER_MACROS_SVH
`define RGB_TO_GRAY_BITPLANE_PACKER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define R2GBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define R2GBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/r2gbp_pkg.sv =====
`default_nettype none

package r2gbp_pkg;

    // Frame size limits
    localparam int WIDTH_CAP  = 1024;
    localparam int HEIGHT_CAP = 1024;
    localparam int COL_W      = $clog2(WIDTH_CAP);
    localparam int ROW_W      = $clog2(HEIGHT_CAP);

    // Register field widths
    localparam int FRAME_WIDTH_W = 11;
    localparam int FRAME_HEIGHT_W = 11;
    localparam int PITCH_W       = 8;
    localparam int PLANE_W       = 2;
    localparam int CFG_DATA_W    = 11;
    localparam int CFG_INDEX_W   = 3;
    localparam int PIXEL_W       = 32;
    localparam int ADDR_W        = 17;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_PITCH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_SELECT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT_IS_RGB = 3'd4;

    // Register reset values
    localparam logic [FRAME_WIDTH_W-1:0]  RST_FRAME_WIDTH  = 11'd800;
    localparam logic [FRAME_HEIGHT_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [PITCH_W-1:0]        RST_ROW_PITCH    = 8'd100;
    localparam logic [PLANE_W-1:0]        RST_PLANE_SELECT = 2'd2;

    // Plane select codes
    localparam logic [PLANE_W-1:0] PLANE_LSB = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_MID = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_MSB = 2'd2;

    // BT.601 luma weights, scaled by 1000, with rounding offset
    localparam int LUMA_SUM_W   = 18;
    localparam int LUMA_R_WT    = 299;
    localparam int LUMA_G_WT    = 587;
    localparam int LUMA_B_WT    = 114;
    localparam int LUMA_ROUND   = 500;
    localparam int LUMA_SCALE   = 1000;
    // gray >> 5 steps by one every 32 gray codes
    localparam int LEVEL_STEP   = 32 * LUMA_SCALE;

    // Level table indexed by the top three bits of gray
    localparam logic [2:0] LEVEL_TABLE [8] = '{3'd3, 3'd2, 3'd1, 3'd0,
                                               3'd7, 3'd6, 3'd5, 3'd4};

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [FRAME_WIDTH_W-1:0]  frame_width;
        logic [FRAME_HEIGHT_W-1:0] frame_height;
        logic [PITCH_W-1:0]        row_pitch_bytes;
        logic [PLANE_W-1:0]        plane_select;
        logic                      format_is_rgb;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/r2gbp_cfg_regs.sv =====
`default_nettype none

module r2gbp_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [r2gbp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [r2gbp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output r2gbp_pkg::cfg_t                           cfg
);

    r2gbp_pkg::cfg_t cfg_reg;
    r2gbp_pkg::cfg_t cfg_next;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                r2gbp_pkg::CFG_FRAME_WIDTH:
                    cfg_next.frame_width = cfg_data[r2gbp_pkg::FRAME_WIDTH_W-1:0];
                r2gbp_pkg::CFG_FRAME_HEIGHT:
                    cfg_next.frame_height = cfg_data[r2gbp_pkg::FRAME_HEIGHT_W-1:0];
                r2gbp_pkg::CFG_ROW_PITCH:
                    cfg_next.row_pitch_bytes = cfg_data[r2gbp_pkg::PITCH_W-1:0];
                r2gbp_pkg::CFG_PLANE_SELECT:
                    cfg_next.plane_select = cfg_data[r2gbp_pkg::PLANE_W-1:0];
                r2gbp_pkg::CFG_FORMAT_IS_RGB:
                    cfg_next.format_is_rgb = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= r2gbp_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height    <= r2gbp_pkg::RST_FRAME_HEIGHT;
            cfg_reg.row_pitch_bytes <= r2gbp_pkg::RST_ROW_PITCH;
            cfg_reg.plane_select    <= r2gbp_pkg::RST_PLANE_SELECT;
            cfg_reg.format_is_rgb   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/r2gbp_luma_plane.sv =====
`default_nettype none

module r2gbp_luma_plane (
    input  wire logic [r2gbp_pkg::PIXEL_W-1:0] pixel,
    input  r2gbp_pkg::cfg_t                    cfg,
    output logic                               plane_bit
);

    logic [7:0]                         red;
    logic [7:0]                         green;
    logic [7:0]                         blue;
    logic [r2gbp_pkg::LUMA_SUM_W-1:0]   luma_sum;
    logic [2:0]                         level_idx;
    logic [2:0]                         level;
    logic                               sel_bit;

    assign red   = pixel[23:16];
    assign green = pixel[15:8];
    assign blue  = pixel[7:0];

    // Weighted sum, scaled by 1000, plus rounding offset (max 255500)
    assign luma_sum =
        r2gbp_pkg::LUMA_SUM_W'(r2gbp_pkg::LUMA_SUM_W'(red)
            * r2gbp_pkg::LUMA_SUM_W'(r2gbp_pkg::LUMA_R_WT))
        + r2gbp_pkg::LUMA_SUM_W'(r2gbp_pkg::LUMA_SUM_W'(green)
            * r2gbp_pkg::LUMA_SUM_W'(r2gbp_pkg::LUMA_G_WT))
        + r2gbp_pkg::LUMA_SUM_W'(r2gbp_pkg::LUMA_SUM_W'(blue)
            * r2gbp_pkg::LUMA_SUM_W'(r2gbp_pkg::LUMA_B_WT))
        + r2gbp_pkg::LUMA_SUM_W'(r2gbp_pkg::LUMA_ROUND);

    // Top three bits of gray: thresholds at multiples of 32000, no divider
    always_comb
    begin
        level_idx = 3'd0;
        for (int k = 1; k < 8; k++)
        begin
            if (luma_sum >= r2gbp_pkg::LUMA_SUM_W'(k * r2gbp_pkg::LEVEL_STEP))
            begin
                level_idx = 3'(k);
            end
        end
    end

    assign level = r2gbp_pkg::LEVEL_TABLE[level_idx];

    // Plane pick; the unused code reads the MSB
    always_comb
    begin
        unique case (cfg.plane_select)
            r2gbp_pkg::PLANE_LSB: sel_bit = level[0];
            r2gbp_pkg::PLANE_MID: sel_bit = level[1];
            default:              sel_bit = level[2];
        endcase
    end

    assign plane_bit = cfg.format_is_rgb & sel_bit;

endmodule

`default_nettype wire

// ===== hw/rtl/r2gbp_packer.sv =====
`default_nettype none

`include "rgb_to_gray_bitplane_packer_macros.svh"

module r2gbp_packer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  r2gbp_pkg::cfg_t                        cfg,
    input  wire logic                              item_valid,
    input  wire logic                              plane_bit,
    output logic                                   advance,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic [7:0]                             packed_byte,
    output logic [r2gbp_pkg::ADDR_W-1:0]           byte_address,
    output logic                                   frame_last
);

    localparam int COL_W = r2gbp_pkg::COL_W;
    localparam int ROW_W = r2gbp_pkg::ROW_W;

    logic [COL_W-1:0]               col_reg;
    logic [COL_W-1:0]               col_next;
    logic [ROW_W-1:0]               row_reg;
    logic [ROW_W-1:0]               row_next;
    logic [7:0]                     acc_reg;
    logic [7:0]                     acc_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [7:0]                     out_byte_reg;
    logic [r2gbp_pkg::ADDR_W-1:0]   out_addr_reg;
    logic                           out_last_reg;

    logic [31:0]                    fw_ext;
    logic [31:0]                    fh_ext;
    logic [COL_W-1:0]               w_m1;
    logic [ROW_W-1:0]               h_m1;
    logic                           last_col;
    logic                           last_row;
    logic [COL_W-1:0]               mcol;
    logic                           emit;
    logic [7:0]                     merged;
    logic [r2gbp_pkg::ADDR_W-1:0]   addr;

    // Saturate the frame size into 1..MAX, held as size minus one
    assign fw_ext = 32'(cfg.frame_width);
    assign fh_ext = 32'(cfg.frame_height);

    always_comb
    begin
        priority if (fw_ext == 32'd0)
            w_m1 = '0;
        else if (fw_ext > 32'(r2gbp_pkg::WIDTH_CAP))
            w_m1 = COL_W'(r2gbp_pkg::WIDTH_CAP - 1);
        else
            w_m1 = COL_W'(fw_ext - 32'd1);
    end

    always_comb
    begin
        priority if (fh_ext == 32'd0)
            h_m1 = '0;
        else if (fh_ext > 32'(r2gbp_pkg::HEIGHT_CAP))
            h_m1 = ROW_W'(r2gbp_pkg::HEIGHT_CAP - 1);
        else
            h_m1 = ROW_W'(fh_ext - 32'd1);
    end

    // Mirrored column; counters past the end act as the last column/row
    assign last_col = (col_reg >= w_m1);
    assign last_row = (row_reg >= h_m1);
    assign mcol     = last_col ? '0 : (w_m1 - col_reg);
    assign emit     = (mcol[2:0] == 3'd0);
    assign merged   = acc_reg | (8'(plane_bit) << (3'd7 - mcol[2:0]));

    assign addr = r2gbp_pkg::ADDR_W'(32'(row_reg) * 32'(cfg.row_pitch_bytes)
                                     + 32'(mcol >> 3));

    // An item moves on unless it has a byte and the result slot is full
    assign advance = item_valid & (~emit | ~out_valid_reg | result_ready);

    // Counter and accumulator update
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        acc_next = acc_reg;
        if (advance)
        begin
            acc_next = emit ? 8'd0 : merged;
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : (row_reg + ROW_W'(1));
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Result slot
    always_comb
    begin
        priority if (advance && emit)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded only with a finished byte
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_byte_reg <= merged;
            out_addr_reg <= addr;
            out_last_reg <= last_col & last_row;
        end
    end

    assign result_valid = out_valid_reg;
    assign packed_byte  = out_byte_reg;
    assign byte_address = out_addr_reg;
    assign frame_last   = out_last_reg;

    // Checks
    `R2GBP_ASSERT_NEXT(a_acc_clear, clk, rst_n, advance && emit, acc_reg == 8'd0,
        "accumulator not cleared after a byte request")
    `R2GBP_ASSERT_NEXT(a_row_wrap, clk, rst_n, advance && last_col && last_row,
        (row_reg == '0) && (col_reg == '0), "counters did not wrap at frame end")
    `R2GBP_ASSERT_NOW(a_stall_cause, clk, rst_n, item_valid && !advance,
        emit && out_valid_reg && !result_ready, "item held without a full result slot")
    `R2GBP_ASSERT_NEXT(a_result_loaded, clk, rst_n, advance && emit, result_valid,
        "finished byte not offered")

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_to_gray_bitplane_packer.sv =====
// Gray bit-plane packer. Takes one XRGB pixel request per clock (pixel_valid /
// pixel_ready) in framebuffer order and, whenever a mirrored 1-bpp byte is
// complete, offers it with its row-major address and a frame_last mark on the
// result channel. Throughput is one pixel per cycle; a pixel passes through the
// input register, then the luma weighting, level table and packing logic, and
// its finished byte is offered from the result register.
// Input is held back only while a finished byte waits in a full result register.
// Configuration is written through cfg_write / cfg_index / cfg_data; the user
// must write it between frames while idle (the block does not enforce this).
// There is no start-up pass: pixels are accepted as soon as reset is released.
`default_nettype none

module rgb_to_gray_bitplane_packer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [r2gbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [r2gbp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              pixel_valid,
    output logic                                   pixel_ready,
    input  wire logic [r2gbp_pkg::PIXEL_W-1:0]     pixel,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic [7:0]                             packed_byte,
    output logic [r2gbp_pkg::ADDR_W-1:0]           byte_address,
    output logic                                   frame_last
);

    r2gbp_pkg::cfg_t                   cfg;
    logic                              in_valid_reg;
    logic                              in_valid_next;
    logic [r2gbp_pkg::PIXEL_W-1:0]     pixel_reg;
    logic                              plane_bit;
    logic                              advance;

    // Input register
    assign pixel_ready   = ~in_valid_reg | advance;
    assign in_valid_next = pixel_ready ? pixel_valid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_valid && pixel_ready)
        begin
            pixel_reg <= pixel;
        end
    end

    r2gbp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    r2gbp_luma_plane u_luma_plane (
        .pixel     (pixel_reg),
        .cfg       (cfg),
        .plane_bit (plane_bit)
    );

    r2gbp_packer u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (in_valid_reg),
        .plane_bit    (plane_bit),
        .advance      (advance),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .packed_byte  (packed_byte),
        .byte_address (byte_address),
        .frame_last   (frame_last)
    );

endmodule

`default_nettype wire
